// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the vsync watch block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define AM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition at one edge is followed by another at the next edge.
`define AM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/vwrm_pkg.sv -----
// Package for the vsync watch and refresh meter: widths, codes, reset values,
// divider request and response types. No dependencies.
`timescale 1ns / 1ps

package vwrm_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned USECS_W  = 20;
    localparam int unsigned ROWS_W   = 12;
    localparam int unsigned ATT_W    = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam int unsigned QUO_W    = 32;
    localparam int unsigned DIV_W    = 23;
    localparam int unsigned CNT_W    = $clog2(QUO_W);
    localparam int unsigned ROWK_W   = 22;
    localparam int unsigned NUM_W    = ROWK_W + QUO_W;
    localparam int unsigned RECIP_W  = 29;
    localparam int unsigned MS_SHIFT = 38;

    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USECS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE    = 2'd3;

    localparam logic KIND_ARM  = 1'b0;
    localparam logic KIND_WAKE = 1'b1;

    localparam logic [ATT_W-1:0]   MAX_ATTEMPTS = 3'd5;
    localparam logic [ATT_W-1:0]   ATT_SAT      = 3'd7;
    localparam logic [TIME_W-1:0]  RATE_RESET   = 32'd31250;
    localparam logic [USECS_W-1:0] USECS_RESET  = 20'd15360;
    localparam logic [ROWS_W-1:0]  ROWS_RESET   = 12'd480;
    localparam logic [DIV_W-1:0]   MS_DIVISOR   = 23'd1000;
    localparam logic [RECIP_W-1:0] MS_RECIP     = 29'd274877907;
    localparam logic [TIME_W-1:0]  RATE_SAT     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               start;
        logic [QUO_W-1:0]   dividend;
        logic [DIV_W-1:0]   rem_init;
        logic [DIV_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quot;
    } t_div_rsp;

endpackage

// ----- hw/rtl/vwrm_div.sv -----
// Shared restoring divider, one quotient bit per cycle, 32 steps per request.
// Depends on vwrm_pkg.
`timescale 1ns / 1ps

module vwrm_div
    import vwrm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [QUO_W-1:0] r_quot;

    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_quot[QUO_W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_quot <= {r_quot[QUO_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_req.rem_init;
                r_div  <= i_req.divisor;
                r_quot <= i_req.dividend;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- hw/rtl/vsync_watch_refresh_meter.sv -----
// Top level of the vsync watch and refresh meter: waiter and attempt control,
// measurement sequencer. Depends on vwrm_pkg, vwrm_div and assert_macros.svh.
//
// Input channel (i_in_valid / o_in_ready) carries one beat per arm request or
// wake event; every beat yields exactly one result beat on the output channel
// (o_out_valid / i_out_ready). Configuration is a plain write port
// (i_cfg_we, i_cfg_idx, i_cfg_data); the user must write it only while the
// block is idle, and the block itself does not enforce this. An item that
// needs no rate measurement goes from accept to S_DONE and from there, once
// the output register is free, into that register. A detected vsync with
// monitoring on and a previous timestamp takes elapsed milliseconds by a
// reciprocal multiplication, then runs two 32-step divisions on the shared
// divider (rounded vsync count, line rate), one after the other; it goes
// straight to S_DONE when the elapsed time is under one millisecond and skips
// the second division when the rate saturates. One item is in work at a time
// and o_in_ready is low until its result moves into the output register.
// A result waiting there does not block the next beat; a stalled receiver
// holds the finished result in the sequencer until the output register frees.
// Reset is synchronous: no waiter, no attempts, detection off, no start time,
// rate 31250, registers at their defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vsync_watch_refresh_meter
    import vwrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic                  i_detected,
    input  logic [TIME_W-1:0]     i_now_us,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_waiter_fired,
    output logic                  o_arm_rejected,
    output logic                  o_detect_failed,
    output logic [TIME_W-1:0]     o_lines_per_second,
    output logic [ATT_W-1:0]      o_attempt_count,
    output logic                  o_detect_active
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MS    = 3'd1;
    localparam logic [2:0] S_VS_ST = 3'd2;
    localparam logic [2:0] S_VS_WT = 3'd3;
    localparam logic [2:0] S_QT_ST = 3'd4;
    localparam logic [2:0] S_QT_WT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic                 r_monitor;
    logic [USECS_W-1:0]   r_usecs;
    logic [ROWS_W-1:0]    r_rows;

    logic                 r_pending;
    logic [ATT_W-1:0]     r_attempts;
    logic                 r_detect;
    logic                 r_first_seen;
    logic [TIME_W-1:0]    r_start;
    logic [TIME_W-1:0]    r_rate;

    logic [2:0]           r_state;
    logic [2:0]           n_state;

    logic                 r_res_fired;
    logic                 r_res_rejected;
    logic                 r_res_failed;

    logic [TIME_W-1:0]    r_elapsed;
    logic [ROWK_W-1:0]    r_rowk;
    logic [DIV_W-1:0]     r_ms;
    logic [NUM_W-1:0]     r_numer;

    logic                 r_out_valid;
    logic                 r_o_fired;
    logic                 r_o_rejected;
    logic                 r_o_failed;
    logic [TIME_W-1:0]    r_o_rate;
    logic [ATT_W-1:0]     r_o_attempts;
    logic                 r_o_detect;

    logic                 w_accept;
    logic                 w_give_up;
    logic                 w_measure;
    logic                 w_out_free;
    logic                 w_saturate;
    logic [USECS_W-1:0]   w_period;
    logic [TIME_W:0]      w_vs_dividend;
    logic [TIME_W+RECIP_W-1:0] w_ms_prod;
    logic [DIV_W-1:0]     w_ms;
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;

    vwrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_give_up  = (i_kind == KIND_WAKE) && (i_detected || (r_attempts > MAX_ATTEMPTS));
    assign w_measure  = w_give_up && i_detected && r_monitor && !r_first_seen;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_period      = (r_usecs == '0) ? USECS_W'(1) : r_usecs;
    assign w_vs_dividend = {1'b0, r_elapsed} + (TIME_W + 1)'(w_period[USECS_W-1:1]);
    assign w_saturate    = {1'b0, r_numer[NUM_W-1:QUO_W]} >= r_ms;

    // elapsed milliseconds: exact floor division by 1000 over the 32-bit range
    assign w_ms_prod = (TIME_W + RECIP_W)'(r_elapsed) * (TIME_W + RECIP_W)'(MS_RECIP);
    assign w_ms      = DIV_W'(w_ms_prod >> MS_SHIFT);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_monitor <= 1'b0;
            r_usecs   <= USECS_RESET;
            r_rows    <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MONITOR: r_monitor <= i_cfg_data[0];
                CFG_USECS:   r_usecs   <= i_cfg_data[USECS_W-1:0];
                CFG_ROWS:    r_rows    <= i_cfg_data[ROWS_W-1:0];
                CFG_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // waiter, attempts and detection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending      <= 1'b0;
            r_attempts     <= '0;
            r_detect       <= 1'b0;
            r_first_seen   <= 1'b1;
            r_start        <= '0;
            r_res_fired    <= 1'b0;
            r_res_rejected <= 1'b0;
            r_res_failed   <= 1'b0;
        end else if (w_accept) begin
            r_res_fired    <= 1'b0;
            r_res_rejected <= 1'b0;
            r_res_failed   <= 1'b0;
            if (i_kind == KIND_ARM) begin
                if (r_pending) begin
                    r_res_rejected <= 1'b1;
                end else begin
                    r_pending  <= 1'b1;
                    r_attempts <= ATT_W'(1);
                    r_detect   <= 1'b1;
                end
            end else if (w_give_up) begin
                if (i_detected && r_monitor) begin
                    r_first_seen <= 1'b0;
                    r_start      <= i_now_us;
                end
                r_res_fired  <= r_pending;
                r_pending    <= 1'b0;
                r_detect     <= 1'b0;
                r_attempts   <= '0;
                r_res_failed <= !i_detected;
            end else if (r_attempts < ATT_SAT) begin
                r_attempts <= r_attempts + 1'b1;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = w_measure ? S_MS : S_DONE;
            S_MS:    n_state = (w_ms == '0) ? S_DONE : S_VS_ST;
            S_VS_ST: n_state = S_VS_WT;
            S_VS_WT: if (w_div_rsp.done) n_state = S_QT_ST;
            S_QT_ST: n_state = w_saturate ? S_DONE : S_QT_WT;
            S_QT_WT: if (w_div_rsp.done) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_div_req = '0;
        unique case (r_state)
            S_VS_ST: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = w_vs_dividend[QUO_W-1:0];
                w_div_req.rem_init = DIV_W'(w_vs_dividend[TIME_W]);
                w_div_req.divisor  = DIV_W'(w_period);
            end
            S_QT_ST: begin
                w_div_req.start    = !w_saturate;
                w_div_req.dividend = r_numer[QUO_W-1:0];
                w_div_req.rem_init = DIV_W'(r_numer[NUM_W-1:QUO_W]);
                w_div_req.divisor  = r_ms;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate  <= RATE_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_QT_ST && w_saturate) begin
                r_rate <= RATE_SAT;
            end else if (r_state == S_QT_WT && w_div_rsp.done) begin
                r_rate <= w_div_rsp.quot;
            end
        end
    end

    // measurement datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_elapsed <= i_now_us - r_start;
            r_rowk    <= ROWK_W'(r_rows) * ROWK_W'(MS_DIVISOR);
        end
        if (r_state == S_MS) begin
            r_ms <= w_ms;
        end
        if (r_state == S_VS_WT && w_div_rsp.done) begin
            r_numer <= NUM_W'(r_rowk) * NUM_W'(w_div_rsp.quot);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_fired    <= r_res_fired;
            r_o_rejected <= r_res_rejected;
            r_o_failed   <= r_res_failed;
            r_o_rate     <= r_rate;
            r_o_attempts <= r_attempts;
            r_o_detect   <= r_detect;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_waiter_fired     = r_o_fired;
    assign o_arm_rejected     = r_o_rejected;
    assign o_detect_failed    = r_o_failed;
    assign o_lines_per_second = r_o_rate;
    assign o_attempt_count    = r_o_attempts;
    assign o_detect_active    = r_o_detect;

    `AM_ASSERT(a_att_bound, i_clk, i_rst_n, r_attempts <= MAX_ATTEMPTS + 3'd1)
    `AM_ASSERT(a_detect_att, i_clk, i_rst_n, !r_detect || (r_attempts != '0))
    `AM_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, w_accept, !o_in_ready)
    `AM_ASSERT(a_fire_reject, i_clk, i_rst_n, !(r_out_valid && r_o_fired && r_o_rejected))

endmodule
